// File: hdl/lrut_pkg.sv
// ----------------------------------------------------------------------------
// lrut_pkg: shared types and constants of the lru tag table
// Transaction payloads, operation codes, sequencer states and the compare
// result that travels from the compare unit to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrut_pkg;

   localparam int KEY_W  = 64;
   localparam int SIZE_W = 20;
   localparam int SLOT_W = 4;

   typedef enum logic [0:0] {
      FUNC_LOOKUP = 1'b0,
      FUNC_ADD    = 1'b1
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [KEY_W-1:0]    key;
      logic [SIZE_W-1:0]   obj_size;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic [SIZE_W-1:0]   found_size;
      logic                evicted;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   // what the compare unit reports for one entry
   typedef struct packed {
      logic key_eq;
      logic stamp_lt;
   } cmp_type;

endpackage

`default_nettype wire

// File: hdl/lrut_cmp.sv
// ----------------------------------------------------------------------------
// lrut_cmp: entry compare unit
// Checks one stored entry against the request key and the running lru bound.
// ----------------------------------------------------------------------------
`default_nettype none

module lrut_cmp #(
   parameter int KEY_BITS   = 64,
   parameter int STAMP_BITS = 32
) (
   input  wire logic [KEY_BITS-1:0]   key_a,
   input  wire logic [KEY_BITS-1:0]   key_b,
   input  wire logic [STAMP_BITS-1:0] stamp,
   input  wire logic [STAMP_BITS-1:0] bound,
   output lrut_pkg::cmp_type          result
);

   always_comb begin
      result.key_eq   = (key_a == key_b);
      result.stamp_lt = (stamp < bound);
   end

endmodule

`default_nettype wire

// File: hdl/lru_tag_table_unit.sv
// ----------------------------------------------------------------------------
// lru_tag_table_unit: fully associative tag table with timestamp lru
// Lookup and add of fixed-width keys, one entry compared per cycle.
// ----------------------------------------------------------------------------
// A lookup walks the filled entries from index 0 upward through one shared
// compare unit fed by a registered memory read, one entry per cycle, and
// stops at the first key match; a lookup on an empty table skips the scan.
// An add into a table that still has room writes the next free slot
// without a scan; an add into a full table scans all ENTRIES stamps for the
// oldest one. The entry memory has a single read port feeding the compare
// unit. req_stall stays high from acceptance until the result is loaded
// into the output register; a finished result may wait in that register
// while the next request is taken. Adds do not check for duplicates: a
// lookup returns the lowest matching index. Stamps and the use counter wrap
// modulo 2^STAMP_BITS. Entry storage has no reset; only filled entries are
// ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_tag_table_unit #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int STAMP_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lrut_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lrut_pkg::rsp_type      rsp_data
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int SIZE_W = lrut_pkg::SIZE_W;
   localparam int SLOT_W = lrut_pkg::SLOT_W;
   localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);

   // sequencer and table bookkeeping
   lrut_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [STAMP_BITS-1:0]   use_cnt_ff, use_cnt_in;

   // latched transaction
   lrut_pkg::func_type      func_ff, func_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [SIZE_W-1:0]       size_ff, size_in;

   // scan state
   logic [CNT_W-1:0]        issue_ff, issue_in;
   logic [CNT_W-1:0]        limit_ff, limit_in;
   logic [STAMP_BITS-1:0]   bound_ff, bound_in;
   logic [IDX_W-1:0]        victim_ff, victim_in;
   logic                    cmp_vld_ff;
   logic [IDX_W-1:0]        cmp_idx_ff;

   // result being built
   logic                    hit_ff, hit_in;
   logic [IDX_W-1:0]        slot_idx_ff, slot_idx_in;
   logic [SIZE_W-1:0]       found_ff, found_in;
   logic                    evict_ff, evict_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   lrut_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   // entry memory
   logic [KEY_BITS-1:0]     entry_key_ff   [ENTRIES];
   logic [SIZE_W-1:0]       entry_size_ff  [ENTRIES];
   logic [STAMP_BITS-1:0]   entry_stamp_ff [ENTRIES];
   logic [KEY_BITS-1:0]     key_rd_ff;
   logic [SIZE_W-1:0]       size_rd_ff;
   logic [STAMP_BITS-1:0]   stamp_rd_ff;

   logic                    req_take;
   logic                    rsp_free;
   logic                    is_add;
   logic                    tbl_full;
   logic                    rd_en;
   logic                    entry_we;
   logic                    stamp_we;
   logic                    match;
   logic                    lower;
   logic                    cmp_last;
   logic [IDX_W+SLOT_W-1:0] slot_wide;
   lrut_pkg::cmp_type       cmp;

   assign req_stall = (state_ff != lrut_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign is_add   = (func_ff == lrut_pkg::FUNC_ADD);
   assign tbl_full = (fill_ff == ENTRIES_CNT);

   // one entry per cycle into the compare unit
   lrut_cmp #(
      .KEY_BITS   (KEY_BITS),
      .STAMP_BITS (STAMP_BITS)
   ) u_cmp (
      .key_a  (key_rd_ff),
      .key_b  (key_ff),
      .stamp  (stamp_rd_ff),
      .bound  (bound_ff),
      .result (cmp)
   );

   assign rd_en    = (state_ff == lrut_pkg::ST_SCAN) && (issue_ff < limit_ff);
   assign match    = cmp_vld_ff && !is_add && cmp.key_eq;
   assign lower    = cmp_vld_ff && is_add && cmp.stamp_lt;
   // the compare stage holds the last entry of the scan
   assign cmp_last = cmp_vld_ff && ((CNT_W'(cmp_idx_ff) + 1'b1) == limit_ff);

   assign slot_wide = {{SLOT_W{1'b0}}, slot_idx_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lrut_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_data.func == lrut_pkg::FUNC_ADD) begin
                  state_in = tbl_full ? lrut_pkg::ST_SCAN : lrut_pkg::ST_WRITE;
               end else begin
                  state_in = (fill_ff == '0) ? lrut_pkg::ST_DONE : lrut_pkg::ST_SCAN;
               end
            end
         end
         lrut_pkg::ST_SCAN: begin
            if (match) begin
               state_in = lrut_pkg::ST_WRITE;
            end else if (cmp_last) begin
               state_in = is_add ? lrut_pkg::ST_WRITE : lrut_pkg::ST_DONE;
            end
         end
         lrut_pkg::ST_WRITE: begin
            state_in = lrut_pkg::ST_DONE;
         end
         lrut_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = lrut_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrut_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      fill_in      = fill_ff;
      use_cnt_in   = use_cnt_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      size_in      = size_ff;
      issue_in     = issue_ff;
      limit_in     = limit_ff;
      bound_in     = bound_ff;
      victim_in    = victim_ff;
      hit_in       = hit_ff;
      slot_idx_in  = slot_idx_ff;
      found_in     = found_ff;
      evict_in     = evict_ff;
      entry_we     = 1'b0;
      stamp_we     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         lrut_pkg::ST_IDLE: begin
            if (req_take) begin
               func_in     = req_data.func;
               key_in      = req_data.key[KEY_BITS-1:0];
               size_in     = req_data.obj_size;
               issue_in    = '0;
               bound_in    = use_cnt_ff;
               victim_in   = '0;
               hit_in      = 1'b0;
               found_in    = '0;
               evict_in    = 1'b0;
               slot_idx_in = '0;
               if (req_data.func == lrut_pkg::FUNC_ADD) begin
                  limit_in = ENTRIES_CNT;
                  // next free slot while there is room
                  if (!tbl_full) begin
                     slot_idx_in = fill_ff[IDX_W-1:0];
                  end
               end else begin
                  limit_in = fill_ff;
               end
            end
         end
         lrut_pkg::ST_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + 1'b1;
            end
            if (match) begin
               hit_in      = 1'b1;
               slot_idx_in = cmp_idx_ff;
               found_in    = size_rd_ff;
            end
            // strictly older stamp takes over, ties keep the lower index
            if (lower) begin
               bound_in  = stamp_rd_ff;
               victim_in = cmp_idx_ff;
            end
            if (cmp_last && is_add) begin
               slot_idx_in = lower ? cmp_idx_ff : victim_ff;
               evict_in    = 1'b1;
            end
         end
         lrut_pkg::ST_WRITE: begin
            stamp_we   = 1'b1;
            entry_we   = is_add;
            use_cnt_in = use_cnt_ff + 1'b1;
            if (is_add && !evict_ff) begin
               fill_in = fill_ff + 1'b1;
            end
         end
         lrut_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.hit        = hit_ff;
               rsp_data_in.slot       = slot_wide[SLOT_W-1:0];
               rsp_data_in.found_size = found_ff;
               rsp_data_in.evicted    = evict_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrut_pkg::ST_IDLE;
         fill_ff      <= '0;
         use_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         use_cnt_ff   <= use_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= rd_en;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      size_ff     <= size_in;
      issue_ff    <= issue_in;
      limit_ff    <= limit_in;
      bound_ff    <= bound_in;
      victim_ff   <= victim_in;
      hit_ff      <= hit_in;
      slot_idx_ff <= slot_idx_in;
      found_ff    <= found_in;
      evict_ff    <= evict_in;
      rsp_data_ff <= rsp_data_in;
      cmp_idx_ff  <= issue_ff[IDX_W-1:0];
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_key_ff[slot_idx_ff]  <= key_ff;
         entry_size_ff[slot_idx_ff] <= size_ff;
      end
      if (stamp_we) begin
         entry_stamp_ff[slot_idx_ff] <= use_cnt_ff;
      end
      if (rd_en) begin
         key_rd_ff   <= entry_key_ff[issue_ff[IDX_W-1:0]];
         size_rd_ff  <= entry_size_ff[issue_ff[IDX_W-1:0]];
         stamp_rd_ff <= entry_stamp_ff[issue_ff[IDX_W-1:0]];
      end
   end

endmodule

`default_nettype wire

// File: hdl/lrut_checker.sv
// ----------------------------------------------------------------------------
// lrut_checker: port-level checks of the lru tag table
// Watches the transaction ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lrut_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire lrut_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire lrut_pkg::rsp_type rsp_data
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one transaction at a time: busy right after acceptance
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // a hit never comes with an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> !rsp_data.evicted)
      else $error("hit and evicted both set");

   // size only reported on a hit
   a_miss_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.found_size == '0)
      else $error("size reported without a hit");

endmodule

bind lru_tag_table_unit lrut_checker u_lrut_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lru_tag_table_unit
// Drives lookup and add transactions through the valid/stall request channel
// and keeps its own copy of the tag table (keys, sizes, use stamps, fill level
// and use counter). Every transaction taken by the block is predicted at
// acceptance, and each response is compared field by field with the oldest
// prediction. A directed sequence comes first, then random traffic under four
// idling patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int ENTRIES       = 16;
   localparam int STAMP_BITS    = 32;
   localparam int KEY_W         = lrut_pkg::KEY_W;
   localparam int SIZE_W        = lrut_pkg::SIZE_W;
   localparam int SLOT_W        = lrut_pkg::SLOT_W;
   localparam int POOL_KEYS     = 24;     // more keys than entries, so evictions happen
   localparam int PHASE_ITEMS   = 155;    // random transactions per idling phase
   localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
   localparam int HOLD_ITEMS    = 20;
   localparam int SETTLE_CYCLES = 48;     // well above the slowest full-table add
   localparam int DRAIN_LIMIT   = 20000;
   localparam int CYCLE_LIMIT   = 400000;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   lrut_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   lrut_pkg::rsp_type rsp_data;

   lru_tag_table_unit #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_W),
      .STAMP_BITS (STAMP_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------
   // shadow copy of the tag table
   // ---------------------------------------------------------------------------
   logic [KEY_W-1:0]      shadow_key   [ENTRIES];
   logic [SIZE_W-1:0]     shadow_size  [ENTRIES];
   logic [STAMP_BITS-1:0] shadow_stamp [ENTRIES];
   int                    shadow_fill = 0;
   logic [STAMP_BITS-1:0] shadow_clock = '0;   // global use counter, wraps naturally

   lrut_pkg::rsp_type pending_outcomes[$];   // predicted responses, oldest first
   logic [KEY_W-1:0]  key_pool [POOL_KEYS];

   int idle_pct  = 0;     // chance per cycle that the sender holds back
   int stall_pct = 0;     // chance per cycle that the receiver stalls
   logic rsp_hold = 1'b0; // forces a stall for the whole hold-off

   int error_count   = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int hit_count     = 0;
   int evict_count   = 0;
   int cycle_count   = 0;

   // works out the response of one transaction and updates the shadow table
   function automatic lrut_pkg::rsp_type table_outcome(input lrut_pkg::req_type r);
      lrut_pkg::rsp_type     o;
      int                    victim;
      logic [STAMP_BITS-1:0] oldest;
      o = '0;
      if (r.func == lrut_pkg::FUNC_LOOKUP) begin
         // first matching entry wins, so duplicates resolve to the lowest index
         for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_key[i] == r.key) begin
               o.hit           = 1'b1;
               o.slot          = SLOT_W'(i);
               o.found_size    = shadow_size[i];
               shadow_stamp[i] = shadow_clock;
               shadow_clock    = shadow_clock + 1'b1;
               break;
            end
         end
      end else begin
         if (shadow_fill < ENTRIES) begin
            victim      = shadow_fill;
            shadow_fill = shadow_fill + 1;
         end else begin
            // oldest stamp strictly below the running bound; ties keep the low index
            victim = 0;
            oldest = shadow_clock;
            for (int i = 0; i < ENTRIES; i++) begin
               if (shadow_stamp[i] < oldest) begin
                  oldest = shadow_stamp[i];
                  victim = i;
               end
            end
            o.evicted = 1'b1;
         end
         shadow_key[victim]   = r.key;
         shadow_size[victim]  = r.obj_size;
         shadow_stamp[victim] = shadow_clock;
         shadow_clock         = shadow_clock + 1'b1;
         o.slot               = SLOT_W'(victim);
      end
      return o;
   endfunction

   function automatic lrut_pkg::req_type make_req(input lrut_pkg::func_type f,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [SIZE_W-1:0] s);
      lrut_pkg::req_type r;
      r.func     = f;
      r.key      = k;
      r.obj_size = s;
      return r;
   endfunction

   function automatic logic [SIZE_W-1:0] random_size();
      return SIZE_W'($urandom_range(32'h000F_FFFF));
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------------------
   // sender: one transaction per call
   // valid is left high after acceptance, so a back-to-back transaction keeps it
   // high without a second assignment in the same step
   // ---------------------------------------------------------------------------
   task automatic issue_request(input lrut_pkg::req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      // taken at this edge: predict now, in acceptance order
      pending_outcomes.push_back(table_outcome(r));
      sent_count++;
   endtask

   // drop valid and wait until every predicted response has come back
   task automatic wait_for_outcomes();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_outcomes.size() != 0 && waited < DRAIN_LIMIT);
   endtask

   // ---------------------------------------------------------------------------
   // receiver: random stall, or solid stall during a hold-off
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(99) < stall_pct);
   end

   task automatic hold_receiver(input int cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // response checker: every accepted response against the oldest prediction
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      lrut_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("response with no transaction outstanding");
         end else begin
            want = pending_outcomes.pop_front();
            checked_count++;
            if (want.hit)     hit_count++;
            if (want.evicted) evict_count++;
            if (rsp_data.hit !== want.hit)
               flag_mismatch($sformatf("hit %b, expected %b", rsp_data.hit, want.hit));
            if (rsp_data.slot !== want.slot)
               flag_mismatch($sformatf("slot %0d, expected %0d", rsp_data.slot, want.slot));
            if (rsp_data.found_size !== want.found_size)
               flag_mismatch($sformatf("found_size %h, expected %h",
                                       rsp_data.found_size, want.found_size));
            if (rsp_data.evicted !== want.evicted)
               flag_mismatch($sformatf("evicted %b, expected %b",
                                       rsp_data.evicted, want.evicted));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", pending_outcomes.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // empty-table miss, fill from slot 0, duplicates, full-table evictions
   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      // miss on empty table
      issue_request(make_req(lrut_pkg::FUNC_LOOKUP, '0, '0));
      issue_request(make_req(lrut_pkg::FUNC_ADD, '0, '0));
      issue_request(make_req(lrut_pkg::FUNC_ADD, '1, '1));
      issue_request(make_req(lrut_pkg::FUNC_LOOKUP, '1, '0));
      // size ignored by lookup
      issue_request(make_req(lrut_pkg::FUNC_LOOKUP, '0, '1));
      // duplicate key
      issue_request(make_req(lrut_pkg::FUNC_ADD, '1, 20'h5A5A5));
      // lowest index wins
      issue_request(make_req(lrut_pkg::FUNC_LOOKUP, '1, '0));
      // fill the remaining slots
      for (int i = 0; i < ENTRIES - 3; i++)
         issue_request(make_req(lrut_pkg::FUNC_ADD, key_pool[4 + i], random_size()));
      // table is full now: every add evicts the stalest entry
      issue_request(make_req(lrut_pkg::FUNC_ADD, key_pool[2], random_size()));
      // refresh a stamp
      issue_request(make_req(lrut_pkg::FUNC_LOOKUP, key_pool[4], '0));
      issue_request(make_req(lrut_pkg::FUNC_ADD, key_pool[3], random_size()));
      // miss, full table
      issue_request(make_req(lrut_pkg::FUNC_LOOKUP, {$urandom, $urandom}, '0));
      issue_request(make_req(lrut_pkg::FUNC_ADD, '1, '1));
      wait_for_outcomes();
   endtask

   // mostly pool keys (hits, refreshes, evictions), the rest random noise
   task automatic test_random_traffic(input int sender_idle, input int receiver_stall);
      lrut_pkg::req_type r;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if ($urandom_range(99) < 80)
            r.key = key_pool[$urandom_range(POOL_KEYS - 1)];
         else
            r.key = {$urandom, $urandom};
         r.func     = ($urandom_range(99) < 35) ? lrut_pkg::FUNC_ADD : lrut_pkg::FUNC_LOOKUP;
         r.obj_size = random_size();
         issue_request(r);
      end
      wait_for_outcomes();
   endtask

   // receiver holds off while the sender keeps pushing, so the block backs up
   task automatic test_full_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      fork
         hold_receiver(HOLD_CYCLES);
      join_none
      for (int n = 0; n < HOLD_ITEMS; n++)
         issue_request(make_req((n % 3 == 0) ? lrut_pkg::FUNC_ADD : lrut_pkg::FUNC_LOOKUP,
                                key_pool[$urandom_range(POOL_KEYS - 1)], random_size()));
      wait_for_outcomes();
   endtask

   initial begin
      // a few boundary patterns in the key pool, the rest random
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = {KEY_W/2{2'b10}};
      key_pool[3] = {KEY_W/2{2'b01}};
      for (int i = 4; i < POOL_KEYS; i++)
         key_pool[i] = {$urandom, $urandom};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic(0, 0);
      test_random_traffic(79, 0);
      test_random_traffic(0, 79);
      test_random_traffic(14, 14);
      test_full_backpressure();

      // let anything still in flight show up as an unexpected response
      stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", pending_outcomes.size()));

      $display("covered %0d lookup/add transactions, %0d responses checked", sent_count,
               checked_count);
      $display("seen %0d lookup hits and %0d evictions across four idling mixes and a hold-off",
               hit_count, evict_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// File: lru_tag_table_unit.f
hdl/lrut_pkg.sv
hdl/lrut_cmp.sv
hdl/lru_tag_table_unit.sv
hdl/lrut_checker.sv
tb/testbench.sv
